FILE: src/local_time_step_cfl_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the local time step block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LOCAL_TIME_STEP_CFL_TOP_ASSERT_SVH
`define LOCAL_TIME_STEP_CFL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define LTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies a consequence
`define LTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);
`else
`define LTS_ASSERT(lbl, prop, msg)
`define LTS_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: src/ltscfl_pkg.sv
// ----------------------------------------------------------------------------
// ltscfl_pkg
// Widths, constants and shared types of the local time step pipeline.
// ----------------------------------------------------------------------------
package ltscfl_pkg;

  // Fixed-point format of the words
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int CFL_W  = 24;
  localparam int UNS_W  = 31;

  // Derived widths
  localparam int PROD_W = 2 * WORD_BITS;             // full product / square sum
  localparam int DOT_W  = PROD_W - FRAC_BITS;        // scaled convective term
  localparam int ROOT_W = WORD_BITS;                 // face length
  localparam int ACU_W  = UNS_W + ROOT_W;            // c * length, unscaled
  localparam int DEN_W  = DOT_W + 2;                 // sum of two radii
  localparam int NUM_W  = CFL_W + UNS_W;             // cfl * volume
  localparam int QUO_W  = UNS_W;                     // time step

  // Stage counts
  localparam int FRONT_STAGES = 3;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int BACK_STAGES  = 3;
  localparam int DIV_STAGES   = QUO_W + 2;
  localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + BACK_STAGES + DIV_STAGES;

  localparam logic [UNS_W-1:0] TS_MAX    = '1;
  localparam logic [CFL_W-1:0] CFL_RESET = 24'd32768;

  // One cell as it enters the pipeline
  typedef struct packed {
    logic signed [WORD_BITS-1:0] jface_lo_x;
    logic signed [WORD_BITS-1:0] jface_lo_y;
    logic signed [WORD_BITS-1:0] jface_hi_x;
    logic signed [WORD_BITS-1:0] jface_hi_y;
    logic signed [WORD_BITS-1:0] iface_lo_x;
    logic signed [WORD_BITS-1:0] iface_lo_y;
    logic signed [WORD_BITS-1:0] iface_hi_x;
    logic signed [WORD_BITS-1:0] iface_hi_y;
    logic signed [WORD_BITS-1:0] velocity_x;
    logic signed [WORD_BITS-1:0] velocity_y;
    logic        [UNS_W-1:0]     sound_speed;
    logic        [UNS_W-1:0]     cell_volume;
  } cell_t;

  // Terms that ride along the square root stages
  typedef struct packed {
    logic [DOT_W-1:0] dot_j;
    logic [DOT_W-1:0] dot_i;
    logic [UNS_W-1:0] snd;
    logic [NUM_W-1:0] num;
  } side_t;

endpackage

FILE: src/ltscfl_front.sv
// ----------------------------------------------------------------------------
// ltscfl_front
// Face averaging, products and squares, convective terms: three stages.
// ----------------------------------------------------------------------------
module ltscfl_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  ltscfl_pkg::cell_t             cell_i,
  input  logic [ltscfl_pkg::CFL_W-1:0]  cfl_i,
  output logic                          out_valid_o,
  output logic [ltscfl_pkg::PROD_W-1:0] sq_j_o,
  output logic [ltscfl_pkg::PROD_W-1:0] sq_i_o,
  output ltscfl_pkg::side_t             side_o
);
  import ltscfl_pkg::*;

  // Floor of the mean of two signed words
  function automatic logic signed [WORD_BITS-1:0] pair_avg(
    input logic signed [WORD_BITS-1:0] lo,
    input logic signed [WORD_BITS-1:0] hi
  );
    logic [WORD_BITS:0] s;
    s = {lo[WORD_BITS-1], lo} + {hi[WORD_BITS-1], hi};
    return s[WORD_BITS:1];
  endfunction

  // Magnitude of a signed sum of two products, scaled back
  function automatic logic [DOT_W-1:0] dot_mag(
    input logic signed [PROD_W-1:0] p0,
    input logic signed [PROD_W-1:0] p1
  );
    logic [PROD_W:0] s;
    logic [PROD_W:0] m;
    s = {p0[PROD_W-1], p0} + {p1[PROD_W-1], p1};
    m = s[PROD_W] ? (~s + 1'b1) : s;
    return m[PROD_W-1:FRAC_BITS];
  endfunction

  logic [2:0]                  valid_q;

  // Stage 1
  logic signed [WORD_BITS-1:0] ajx_q, ajy_q, aix_q, aiy_q, u1_q, v1_q;
  logic [UNS_W-1:0]            c1_q;
  logic [NUM_W-1:0]            num1_q;

  // Stage 2
  logic signed [PROD_W-1:0]    uj_q, vj_q, ui_q, vi_q;
  logic [PROD_W-1:0]           sjx_q, sjy_q, six_q, siy_q;
  logic [UNS_W-1:0]            c2_q;
  logic [NUM_W-1:0]            num2_q;

  // Stage 3
  logic [DOT_W-1:0]            dotj_q, doti_q;
  logic [PROD_W-1:0]           sqj_q, sqi_q;
  logic [UNS_W-1:0]            c3_q;
  logic [NUM_W-1:0]            num3_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], in_valid_i};
    end
  end

  // Average face pairs, scale the volume
  always_ff @(posedge clk_i) begin
    ajx_q  <= pair_avg(cell_i.jface_lo_x, cell_i.jface_hi_x);
    ajy_q  <= pair_avg(cell_i.jface_lo_y, cell_i.jface_hi_y);
    aix_q  <= pair_avg(cell_i.iface_lo_x, cell_i.iface_hi_x);
    aiy_q  <= pair_avg(cell_i.iface_lo_y, cell_i.iface_hi_y);
    u1_q   <= cell_i.velocity_x;
    v1_q   <= cell_i.velocity_y;
    c1_q   <= cell_i.sound_speed;
    num1_q <= cfl_i * cell_i.cell_volume;
  end

  // Form velocity products and normal squares
  always_ff @(posedge clk_i) begin
    uj_q   <= u1_q * ajx_q;
    vj_q   <= v1_q * ajy_q;
    ui_q   <= u1_q * aix_q;
    vi_q   <= v1_q * aiy_q;
    sjx_q  <= ajx_q * ajx_q;
    sjy_q  <= ajy_q * ajy_q;
    six_q  <= aix_q * aix_q;
    siy_q  <= aiy_q * aiy_q;
    c2_q   <= c1_q;
    num2_q <= num1_q;
  end

  // Sum into convective terms and square lengths
  always_ff @(posedge clk_i) begin
    dotj_q <= dot_mag(uj_q, vj_q);
    doti_q <= dot_mag(ui_q, vi_q);
    sqj_q  <= sjx_q + sjy_q;
    sqi_q  <= six_q + siy_q;
    c3_q   <= c2_q;
    num3_q <= num2_q;
  end

  assign out_valid_o  = valid_q[2];
  assign sq_j_o       = sqj_q;
  assign sq_i_o       = sqi_q;
  assign side_o.dot_j = dotj_q;
  assign side_o.dot_i = doti_q;
  assign side_o.snd   = c3_q;
  assign side_o.num   = num3_q;

endmodule

FILE: src/ltscfl_sqrt.sv
// ----------------------------------------------------------------------------
// ltscfl_sqrt
// Two-lane pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`include "local_time_step_cfl_top_assert.svh"

module ltscfl_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ltscfl_pkg::PROD_W-1:0] sq_j_i,
  input  logic [ltscfl_pkg::PROD_W-1:0] sq_i_i,
  input  ltscfl_pkg::side_t             side_i,
  output logic                          out_valid_o,
  output logic [ltscfl_pkg::ROOT_W-1:0] root_j_o,
  output logic [ltscfl_pkg::ROOT_W-1:0] root_i_o,
  output ltscfl_pkg::side_t             side_o
);
  import ltscfl_pkg::*;

  localparam int LANES = 2;
  localparam int LAST  = SQRT_STAGES - 1;

  // Remainder and partial root of one lane
  typedef struct packed {
    logic [PROD_W-1:0] x;
    logic [PROD_W-1:0] r;
  } sq_t;

  // One digit of the root, stage k
  function automatic sq_t sq_step(input sq_t s, input int k);
    logic [PROD_W-1:0] b;
    logic [PROD_W-1:0] trial;
    sq_t               n;
    b     = {{(PROD_W-1){1'b0}}, 1'b1} << (PROD_W - 2 - 2 * k);
    trial = s.r + b;
    if (s.x >= trial) begin
      n.x = s.x - trial;
      n.r = (s.r >> 1) + b;
    end else begin
      n.x = s.x;
      n.r = s.r >> 1;
    end
    return n;
  endfunction

  logic [SQRT_STAGES-1:0] valid_q;
  sq_t                    st_q   [LANES][SQRT_STAGES];
  sq_t                    st_d   [LANES][SQRT_STAGES];
  side_t                  side_q [SQRT_STAGES];
  sq_t                    seed   [LANES];

  assign seed[0] = '{x: sq_j_i, r: '0};
  assign seed[1] = '{x: sq_i_i, r: '0};

  // Step every stage of both lanes
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      st_d[l][0] = sq_step(seed[l], 0);
      for (int k = 1; k < SQRT_STAGES; k++) begin
        st_d[l][k] = sq_step(st_q[l][k-1], k);
      end
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SQRT_STAGES-2:0], in_valid_i};
    end
  end

  // Hold stage data and carried terms
  always_ff @(posedge clk_i) begin
    st_q      <= st_d;
    side_q[0] <= side_i;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  assign out_valid_o = valid_q[LAST];
  assign root_j_o    = st_q[0][LAST].r[ROOT_W-1:0];
  assign root_i_o    = st_q[1][LAST].r[ROOT_W-1:0];
  assign side_o      = side_q[LAST];

  // The final remainder never exceeds twice the root
  `LTS_ASSERT_IMP(a_root_j_tight, valid_q[LAST], (st_q[0][LAST].x <= (st_q[0][LAST].r << 1)), "root_j remainder too large")
  `LTS_ASSERT_IMP(a_root_i_tight, valid_q[LAST], (st_q[1][LAST].x <= (st_q[1][LAST].r << 1)), "root_i remainder too large")

endmodule

FILE: src/ltscfl_back.sv
// ----------------------------------------------------------------------------
// ltscfl_back
// Acoustic terms, spectral radii and their sum: three stages.
// ----------------------------------------------------------------------------
module ltscfl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ltscfl_pkg::ROOT_W-1:0] root_j_i,
  input  logic [ltscfl_pkg::ROOT_W-1:0] root_i_i,
  input  ltscfl_pkg::side_t             side_i,
  output logic                          out_valid_o,
  output logic [ltscfl_pkg::DEN_W-1:0]  den_o,
  output logic [ltscfl_pkg::NUM_W-1:0]  num_o
);
  import ltscfl_pkg::*;

  logic [2:0]        valid_q;
  logic [ACU_W-1:0]  acj_q, aci_q;
  logic [DOT_W-1:0]  dotj_q, doti_q;
  logic [NUM_W-1:0]  num1_q, num2_q, num3_q;
  logic [DEN_W-2:0]  radj_q, radi_q;
  logic [DEN_W-1:0]  den_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], in_valid_i};
    end
  end

  // Multiply sound speed by face lengths
  always_ff @(posedge clk_i) begin
    acj_q  <= side_i.snd * root_j_i;
    aci_q  <= side_i.snd * root_i_i;
    dotj_q <= side_i.dot_j;
    doti_q <= side_i.dot_i;
    num1_q <= side_i.num;
  end

  // Add convective and scaled acoustic terms per direction
  always_ff @(posedge clk_i) begin
    radj_q <= (DEN_W-1)'(dotj_q) + (DEN_W-1)'(acj_q[ACU_W-1:FRAC_BITS]);
    radi_q <= (DEN_W-1)'(doti_q) + (DEN_W-1)'(aci_q[ACU_W-1:FRAC_BITS]);
    num2_q <= num1_q;
  end

  // Sum both directions
  always_ff @(posedge clk_i) begin
    den_q  <= {1'b0, radj_q} + {1'b0, radi_q};
    num3_q <= num2_q;
  end

  assign out_valid_o = valid_q[2];
  assign den_o       = den_q;
  assign num_o       = num3_q;

endmodule

FILE: src/ltscfl_div.sv
// ----------------------------------------------------------------------------
// ltscfl_div
// Overflow check, pipelined restoring divide, saturating output register.
// ----------------------------------------------------------------------------
`include "local_time_step_cfl_top_assert.svh"

module ltscfl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ltscfl_pkg::DEN_W-1:0]  den_i,
  input  logic [ltscfl_pkg::NUM_W-1:0]  num_i,
  output logic                          done_o,
  output logic [ltscfl_pkg::UNS_W-1:0]  time_step_o,
  output logic                          saturated_o
);
  import ltscfl_pkg::*;

  localparam int TW   = DEN_W + QUO_W - 1;
  localparam int LAST = QUO_W - 1;

  // Partial remainder and quotient
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] q;
  } dv_t;

  // One quotient bit, stage k
  function automatic dv_t div_step(input dv_t s, input logic [DEN_W-1:0] d, input int k);
    logic [TW-1:0] trial;
    logic          ge;
    dv_t           n;
    trial = {{(QUO_W-1){1'b0}}, d} << (QUO_W - 1 - k);
    ge    = {{(TW-NUM_W){1'b0}}, s.rem} >= trial;
    n.rem = ge ? (s.rem - trial[NUM_W-1:0]) : s.rem;
    n.q   = {s.q[QUO_W-2:0], ge};
    return n;
  endfunction

  logic                   chk_valid_q, chk_sat_q;
  logic [DEN_W-1:0]       chk_den_q;
  logic [NUM_W-1:0]       chk_num_q;
  logic                   sat_d;

  logic [QUO_W-1:0]       valid_q;
  logic [QUO_W-1:0]       sat_q;
  logic [DEN_W-1:0]       den_q [QUO_W];
  dv_t                    dv_q  [QUO_W];
  dv_t                    dv_d  [QUO_W];

  logic                   done_q, out_sat_q;
  logic [UNS_W-1:0]       ts_q;

  // Flag a zero denominator or a quotient past the top
  assign sat_d = (den_i == '0) ||
                 ({{(TW+1-NUM_W){1'b0}}, num_i} >= {den_i, {QUO_W{1'b0}}});

  // Step every divide stage
  always_comb begin
    dv_d[0] = div_step('{rem: chk_num_q, q: '0}, chk_den_q, 0);
    for (int k = 1; k < QUO_W; k++) begin
      dv_d[k] = div_step(dv_q[k-1], den_q[k-1], k);
    end
  end

  // Advance valid bits and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_valid_q <= 1'b0;
      valid_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      chk_valid_q <= in_valid_i;
      valid_q     <= {valid_q[QUO_W-2:0], chk_valid_q};
      done_q      <= valid_q[LAST];
    end
  end

  // Hold operands, partial results and the output word
  always_ff @(posedge clk_i) begin
    chk_den_q <= den_i;
    chk_num_q <= num_i;
    chk_sat_q <= sat_d;
    dv_q      <= dv_d;
    den_q[0]  <= chk_den_q;
    sat_q     <= {sat_q[QUO_W-2:0], chk_sat_q};
    for (int k = 1; k < QUO_W; k++) begin
      den_q[k] <= den_q[k-1];
    end
    out_sat_q <= sat_q[LAST];
    ts_q      <= sat_q[LAST] ? TS_MAX : dv_q[LAST].q;
  end

  assign done_o      = done_q;
  assign time_step_o = ts_q;
  assign saturated_o = out_sat_q;

  // A finished quotient leaves a remainder below the divisor
  `LTS_ASSERT_IMP(a_rem_below_den, valid_q[LAST] && !sat_q[LAST], (dv_q[LAST].rem < den_q[LAST]), "divide remainder not below divisor")
  // A zero denominator comes out saturated
  `LTS_ASSERT_IMP(a_zero_den_sat, chk_valid_q && (chk_den_q == '0), ##(QUO_W+1) (done_o && saturated_o), "zero denominator not saturated")

endmodule

FILE: src/local_time_step_cfl_top.sv
// ----------------------------------------------------------------------------
// local_time_step_cfl_top
// Local time step of one finite-volume cell: CFL * volume / summed spectral radii.
// ----------------------------------------------------------------------------
// Throughput: one cell per cycle; busy stays low, start may be held every cycle.
// The pipeline holds a 32-stage square root and a 31-stage divider.
// Reset clears all valid bits and sets cfl_number to 0.5; words in flight drop.
// The receiver cannot stall: each result shows for exactly one cycle.
module local_time_step_cfl_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [ltscfl_pkg::CFL_W-1:0]  cfg_wdata_i,
  input  logic signed [31:0]            jface_lo_x_i,
  input  logic signed [31:0]            jface_lo_y_i,
  input  logic signed [31:0]            jface_hi_x_i,
  input  logic signed [31:0]            jface_hi_y_i,
  input  logic signed [31:0]            iface_lo_x_i,
  input  logic signed [31:0]            iface_lo_y_i,
  input  logic signed [31:0]            iface_hi_x_i,
  input  logic signed [31:0]            iface_hi_y_i,
  input  logic signed [31:0]            velocity_x_i,
  input  logic signed [31:0]            velocity_y_i,
  input  logic [ltscfl_pkg::UNS_W-1:0]  sound_speed_i,
  input  logic [ltscfl_pkg::UNS_W-1:0]  cell_volume_i,
  output logic                          done_o,
  output logic [ltscfl_pkg::UNS_W-1:0]  time_step_o,
  output logic                          saturated_o
);
  import ltscfl_pkg::*;

  logic [CFL_W-1:0]  cfl_q;
  cell_t             in_cell;
  logic              accept;

  logic              fr_valid;
  logic [PROD_W-1:0] fr_sq_j, fr_sq_i;
  side_t             fr_side;

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root_j, sq_root_i;
  side_t             sq_side;

  logic              bk_valid;
  logic [DEN_W-1:0]  bk_den;
  logic [NUM_W-1:0]  bk_num;

  // Hold the Courant number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfl_q <= CFL_RESET;
    end else if (cfg_we_i) begin
      cfl_q <= cfg_wdata_i;
    end
  end

  // Never stall the host
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_cell.jface_lo_x  = jface_lo_x_i;
  assign in_cell.jface_lo_y  = jface_lo_y_i;
  assign in_cell.jface_hi_x  = jface_hi_x_i;
  assign in_cell.jface_hi_y  = jface_hi_y_i;
  assign in_cell.iface_lo_x  = iface_lo_x_i;
  assign in_cell.iface_lo_y  = iface_lo_y_i;
  assign in_cell.iface_hi_x  = iface_hi_x_i;
  assign in_cell.iface_hi_y  = iface_hi_y_i;
  assign in_cell.velocity_x  = velocity_x_i;
  assign in_cell.velocity_y  = velocity_y_i;
  assign in_cell.sound_speed = sound_speed_i;
  assign in_cell.cell_volume = cell_volume_i;

  ltscfl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .cell_i      (in_cell),
    .cfl_i       (cfl_q),
    .out_valid_o (fr_valid),
    .sq_j_o      (fr_sq_j),
    .sq_i_o      (fr_sq_i),
    .side_o      (fr_side)
  );

  ltscfl_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .sq_j_i      (fr_sq_j),
    .sq_i_i      (fr_sq_i),
    .side_i      (fr_side),
    .out_valid_o (sq_valid),
    .root_j_o    (sq_root_j),
    .root_i_o    (sq_root_i),
    .side_o      (sq_side)
  );

  ltscfl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .root_j_i    (sq_root_j),
    .root_i_i    (sq_root_i),
    .side_i      (sq_side),
    .out_valid_o (bk_valid),
    .den_o       (bk_den),
    .num_o       (bk_num)
  );

  ltscfl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .den_i       (bk_den),
    .num_i       (bk_num),
    .done_o      (done_o),
    .time_step_o (time_step_o),
    .saturated_o (saturated_o)
  );

endmodule
